[hw/rtl/nms_pkg.sv]
// Shared types and helpers for the box NMS block.
// Used by nms_cell, nms_iou and box_non_max_suppression.
`timescale 1ns / 1ps
package nms_pkg;

  typedef struct packed {
    logic [14:0] mid_x;
    logic [14:0] mid_y;
    logic [14:0] box_width;
    logic [14:0] box_height;
    logic [15:0] objectness;
    logic [15:0] class_zero_score;
    logic [15:0] class_one_score;
    logic [15:0] class_two_score;
    logic        last;
  } in_t;

  typedef struct packed {
    logic signed [15:0] left_edge;
    logic signed [15:0] top_edge;
    logic signed [15:0] right_edge;
    logic signed [15:0] bottom_edge;
    logic [15:0]        box_score;
    logic [1:0]         class_index;
    logic               box_valid;
    logic               overflowed;
    logic               last_result;
  } out_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic [15:0]        score;
    logic [1:0]         cls;
  } entry_t;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_INS  = 2'd1,
    OP_POP  = 2'd2,
    OP_PUSH = 2'd3
  } cell_op_t;

  typedef struct packed {
    logic valid;
    logic take;
  } link_t;

  localparam logic CFG_SCORE_THR = 1'b0;
  localparam logic CFG_IOU_THR   = 1'b1;
  localparam logic [15:0] SCORE_THR_RST = 16'd26214;
  localparam logic [15:0] IOU_THR_RST   = 16'd32768;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    begin
      if (v > 17'sd32767) r = 16'sh7fff;
      else if (v < -17'sd32768) r = 16'sh8000;
      else r = v[15:0];
      return r;
    end
  endfunction

  // max(0, hi - lo) for signed 16-bit edges
  function automatic logic [15:0] clamp_diff(input logic signed [15:0] hi,
                                             input logic signed [15:0] lo);
    logic signed [16:0] d;
    begin
      d = {hi[15], hi} - {lo[15], lo};
      return d[16] ? 16'd0 : d[15:0];
    end
  endfunction

endpackage

[hw/rtl/nms_cell.sv]
// One cell of the sorted box chain: holds one entry and its valid bit.
// Depends on nms_pkg.
`timescale 1ns / 1ps
module nms_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  nms_pkg::cell_op_t op,
  input  nms_pkg::entry_t   new_entry,
  input  nms_pkg::entry_t   prev_entry,
  input  nms_pkg::link_t    prev_link,
  input  nms_pkg::entry_t   next_entry,
  input  logic              next_valid,
  output nms_pkg::entry_t   entry,
  output nms_pkg::link_t    link
);

  nms_pkg::entry_t entry_r, entry_nxt;
  logic            valid_r, valid_nxt;
  logic            take;

  assign take  = !valid_r || (new_entry.score > entry_r.score);
  assign entry = entry_r;
  assign link  = '{valid: valid_r, take: take};

  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (op)
      nms_pkg::OP_INS: begin
        if (prev_link.take) begin
          entry_nxt = prev_entry;
          valid_nxt = prev_link.valid;
        end else if (take) begin
          entry_nxt = new_entry;
          valid_nxt = 1'b1;
        end
      end
      nms_pkg::OP_POP: begin
        entry_nxt = next_entry;
        valid_nxt = next_valid;
      end
      nms_pkg::OP_PUSH: begin
        if (!valid_r && prev_link.valid) begin
          entry_nxt = new_entry;
          valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[hw/rtl/nms_iou.sv]
// Pipelined overlap test of two corner boxes against the IoU threshold.
// Depends on nms_pkg.
`timescale 1ns / 1ps
module nms_iou (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  nms_pkg::entry_t box_a,
  input  nms_pkg::entry_t box_b,
  input  logic [31:0]     area_a,
  input  logic [15:0]     iou_thr,
  output logic            done,
  output logic            survive
);

  logic [6:0]  vld_r;
  logic [15:0] dx_r, dy_r, wb_r, hb_r, thr_lo_r;
  logic [31:0] area_a_r, inter_r, area_b_r, plo_r;
  logic [32:0] uni_r, phi_r;
  logic        survive_r;
  logic signed [15:0] lo_x, hi_x, lo_y, hi_y;
  logic [32:0] sum_areas;
  logic [48:0] prod;

  assign lo_x = (box_a.left > box_b.left) ? box_a.left : box_b.left;
  assign hi_x = (box_a.right < box_b.right) ? box_a.right : box_b.right;
  assign lo_y = (box_a.top > box_b.top) ? box_a.top : box_b.top;
  assign hi_y = (box_a.bottom < box_b.bottom) ? box_a.bottom : box_b.bottom;
  assign sum_areas = {1'b0, area_a_r} + {1'b0, area_b_r};
  assign prod = {phi_r, 16'd0} + {17'd0, plo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[5:0], start};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dx_r     <= nms_pkg::clamp_diff(hi_x, lo_x);
      dy_r     <= nms_pkg::clamp_diff(hi_y, lo_y);
      wb_r     <= nms_pkg::clamp_diff(box_b.right, box_b.left);
      hb_r     <= nms_pkg::clamp_diff(box_b.bottom, box_b.top);
      area_a_r <= area_a;
      thr_lo_r <= iou_thr;
    end
    if (vld_r[0]) inter_r <= dx_r * dy_r;
    if (vld_r[1]) area_b_r <= wb_r * hb_r;
    if (vld_r[2]) uni_r <= (sum_areas > {1'b0, inter_r}) ?
                           sum_areas - {1'b0, inter_r} : 33'd0;
    if (vld_r[3]) plo_r <= thr_lo_r * uni_r[15:0];
    if (vld_r[4]) phi_r <= thr_lo_r * uni_r[32:16];
    if (vld_r[5]) survive_r <= (uni_r != 33'd0) && ({1'b0, inter_r, 16'd0} <= prod);
  end

  assign done    = vld_r[6];
  assign survive = survive_r;

endmodule

[hw/rtl/box_non_max_suppression.sv]
// Greedy IoU non-maximum suppression over the predictions of one image.
// Depends on nms_pkg, nms_cell and nms_iou.
//
// Usage: predictions enter on in_ (valid/stall), one transfer per cycle while
// loading. Each candidate scoring above the score threshold is inserted, while
// there is room, into a chain of MAX_BOXES cells kept sorted by descending
// score, ties in arrival order. After the transfer marked last, in_stall stays
// high while the chain is drained: the head box is taken as kept, every
// remaining box passes through the IoU pipeline once and is requeued at the
// tail if it survives. Each compare waits for the IoU result before the next
// box is taken from the head.
// Each kept box is presented on out_ from a holding register; out_stall
// freezes the drain until the transfer. The final result carries
// last_result; an image with no survivor gives one result with box_valid 0.
// cfg_ writes set the thresholds; write them only while idle.
// Reset empties the chain, clears the overflow flag and loads the default
// thresholds; in_stall is high during reset and drops as soon as reset is
// released.
`timescale 1ns / 1ps
module box_non_max_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  nms_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output nms_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_data
);

  localparam int CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [5:0] {
    ST_LOAD = 6'b000001,
    ST_POPA = 6'b000010,
    ST_SCAN = 6'b000100,
    ST_WAIT = 6'b001000,
    ST_PUSH = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] score_thr_r, iou_thr_r;
  logic [CW-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic ovf_r, ovf_nxt;
  logic s1_valid_r, s1_last_r;
  logic [31:0] s1_prod_r;
  nms_pkg::entry_t s1_entry_r, in_entry;
  logic [1:0] in_cls;
  logic [15:0] in_best;
  nms_pkg::entry_t a_r, a_nxt, b_r, b_nxt;
  logic [31:0] area_a_r, area_a_nxt;
  logic out_valid_r, out_valid_nxt;
  nms_pkg::out_t out_r, out_nxt;
  nms_pkg::cell_op_t op;
  nms_pkg::entry_t new_entry;
  nms_pkg::entry_t ent [MAX_BOXES];
  nms_pkg::link_t  lnk [MAX_BOXES];
  logic [MAX_BOXES-1:0] valid_vec;
  logic in_xfer, out_xfer, keep, iou_start, iou_done, iou_survive;

  assign in_stall  = !rst_n || (state_r != ST_LOAD) || (s1_valid_r && s1_last_r);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_xfer  = out_valid_r && !out_stall;

  always_comb begin
    in_best = in_data.class_zero_score;
    in_cls  = 2'd0;
    if (in_data.class_one_score > in_best) begin
      in_best = in_data.class_one_score;
      in_cls  = 2'd1;
    end
    if (in_data.class_two_score > in_best) begin
      in_best = in_data.class_two_score;
      in_cls  = 2'd2;
    end
    in_entry.left   = nms_pkg::sat16(17'({2'b0, in_data.mid_x}) -
                                     17'({3'b0, in_data.box_width[14:1]}));
    in_entry.top    = nms_pkg::sat16(17'({2'b0, in_data.mid_y}) -
                                     17'({3'b0, in_data.box_height[14:1]}));
    in_entry.right  = nms_pkg::sat16(17'({2'b0, in_data.mid_x}) -
                                     17'({3'b0, in_data.box_width[14:1]}) +
                                     17'({2'b0, in_data.box_width}));
    in_entry.bottom = nms_pkg::sat16(17'({2'b0, in_data.mid_y}) -
                                     17'({3'b0, in_data.box_height[14:1]}) +
                                     17'({2'b0, in_data.box_height}));
    in_entry.score  = '0;
    in_entry.cls    = in_cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_prod_r  <= in_data.objectness * in_best;
      s1_entry_r <= in_entry;
      s1_last_r  <= in_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_thr_r <= nms_pkg::SCORE_THR_RST;
      iou_thr_r   <= nms_pkg::IOU_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nms_pkg::CFG_SCORE_THR: score_thr_r <= cfg_data;
        nms_pkg::CFG_IOU_THR:   iou_thr_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign keep = s1_prod_r[31:16] > score_thr_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    area_a_nxt    = area_a_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    op            = nms_pkg::OP_NOP;
    new_entry     = b_r;
    iou_start     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        new_entry       = s1_entry_r;
        new_entry.score = s1_prod_r[31:16];
        if (s1_valid_r) begin
          if (keep && (cnt_r < CW'(MAX_BOXES))) begin
            op      = nms_pkg::OP_INS;
            cnt_nxt = cnt_r + 1'b1;
          end else if (keep) begin
            ovf_nxt = 1'b1;
          end
          if (s1_last_r) state_nxt = ST_POPA;
        end
      end
      ST_POPA: begin
        if (cnt_r == '0) begin
          out_nxt       = '0;
          out_nxt.overflowed  = ovf_r;
          out_nxt.last_result = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          a_nxt      = ent[0];
          area_a_nxt = nms_pkg::clamp_diff(ent[0].right, ent[0].left) *
                       nms_pkg::clamp_diff(ent[0].bottom, ent[0].top);
          op         = nms_pkg::OP_POP;
          cnt_nxt    = cnt_r - 1'b1;
          rem_nxt    = cnt_r - 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rem_r == '0) begin
          out_nxt.left_edge   = a_r.left;
          out_nxt.top_edge    = a_r.top;
          out_nxt.right_edge  = a_r.right;
          out_nxt.bottom_edge = a_r.bottom;
          out_nxt.box_score   = a_r.score;
          out_nxt.class_index = a_r.cls;
          out_nxt.box_valid   = 1'b1;
          out_nxt.overflowed  = ovf_r;
          out_nxt.last_result = (cnt_r == '0);
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_EMIT;
        end else begin
          b_nxt     = ent[0];
          op        = nms_pkg::OP_POP;
          iou_start = 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
          rem_nxt   = rem_r - 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (iou_done) state_nxt = iou_survive ? ST_PUSH : ST_SCAN;
      end
      ST_PUSH: begin
        op        = nms_pkg::OP_PUSH;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_result) begin
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_POPA;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      rem_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    area_a_r <= area_a_nxt;
    out_r    <= out_nxt;
  end

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    nms_pkg::entry_t pe, ne;
    nms_pkg::link_t  pl;
    logic            nv;
    if (i == 0) begin : g_head
      assign pe = ent[0];
      assign pl = '{valid: 1'b1, take: 1'b0};
    end else begin : g_body
      assign pe = ent[i-1];
      assign pl = lnk[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_tail
      assign ne = ent[i];
      assign nv = 1'b0;
    end else begin : g_mid
      assign ne = ent[i+1];
      assign nv = lnk[i+1].valid;
    end
    nms_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .op         (op),
      .new_entry  (new_entry),
      .prev_entry (pe),
      .prev_link  (pl),
      .next_entry (ne),
      .next_valid (nv),
      .entry      (ent[i]),
      .link       (lnk[i])
    );
    assign valid_vec[i] = lnk[i].valid;
  end

  nms_iou u_iou (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (iou_start),
    .box_a   (a_r),
    .box_b   (ent[0]),
    .area_a  (area_a_r),
    .iou_thr (iou_thr_r),
    .done    (iou_done),
    .survive (iou_survive)
  );

  a_cnt_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(cnt_r))
    else $error("chain occupancy does not match count");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_BOXES))
    else $error("count above capacity");

  a_out_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == ST_EMIT)
    else $error("result shown outside emit");

  a_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> state_r == ST_LOAD)
    else $error("input transfer while draining");

endmodule
